[hw/rtl/multi_tap_keypad_text_entry_unit_defines.svh]
// Assertion macros shared by the keypad text entry design.
`ifndef MULTI_TAP_KEYPAD_TEXT_ENTRY_UNIT_DEFINES_SVH
`define MULTI_TAP_KEYPAD_TEXT_ENTRY_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define MTK_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define MTK_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hw/rtl/mtk_pkg.sv]
package mtk_pkg;

	// Key codes.
	localparam logic [3:0] KEY_A    = 4'd10;
	localparam logic [3:0] KEY_B    = 4'd11;
	localparam logic [3:0] KEY_C    = 4'd12;
	localparam logic [3:0] KEY_D    = 4'd13;
	localparam logic [3:0] KEY_STAR = 4'd14;
	localparam logic [3:0] KEY_HASH = 4'd15;
	localparam logic [3:0] KEY_TWO  = 4'd2;
	localparam logic [3:0] KEY_NINE = 4'd9;

	localparam logic [15:0] TIMEOUT_RST = 16'd1500;
	localparam logic [6:0]  ASCII_SPACE = 7'h20;
	localparam logic [6:0]  ASCII_ZERO  = 7'h30;
	localparam logic [6:0]  ASCII_NONE  = 7'h00;

	// Result queue between the decoder and the output side.
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [2:0] {
		KIND_COMMIT = 3'd0,
		KIND_PROV   = 3'd1,
		KIND_DELETE = 3'd2,
		KIND_ENTER  = 3'd3,
		KIND_MODE   = 3'd4,
		KIND_BACK   = 3'd5
	} event_kind_t;

	// One text event.
	typedef struct packed {
		event_kind_t kind;
		logic [6:0]  chr;
		logic        alpha;
	} rec_t;

	// Everything one press produces: one or two events.
	typedef struct packed {
		logic two;
		rec_t first;
		rec_t second;
	} job_t;

	// True for the groups with four letters (PQRS and WXYZ).
	function automatic logic group_has_four(input logic [3:0] k);
		return (k == 4'd7) || (k == 4'd9);
	endfunction

	// First letter of the group on key k (2..9).
	function automatic logic [6:0] group_first(input logic [3:0] k);
		logic [6:0] r;
		unique case (k)
			4'd2:    r = 7'h41;
			4'd3:    r = 7'h44;
			4'd4:    r = 7'h47;
			4'd5:    r = 7'h4A;
			4'd6:    r = 7'h4D;
			4'd7:    r = 7'h50;
			4'd8:    r = 7'h54;
			4'd9:    r = 7'h57;
			4'd10:   r = 7'h41;
			4'd11:   r = 7'h44;
			4'd12:   r = 7'h47;
			4'd13:   r = 7'h4A;
			4'd14:   r = 7'h4D;
			4'd15:   r = 7'h50;
			4'd0:    r = 7'h54;
			default: r = 7'h57;
		endcase
		return r;
	endfunction

	// Letter at tap position idx of the group on key k, wrapping in a group of three.
	function automatic logic [6:0] letter_of(input logic [3:0] k, input logic [1:0] idx);
		logic [1:0] pos;
		pos = (!group_has_four(k) && idx == 2'd3) ? 2'd0 : idx;
		return group_first(k) + {5'd0, pos};
	endfunction

	// Tap position after one more press of the same key.
	function automatic logic [1:0] next_tap(input logic [3:0] k, input logic [1:0] idx);
		logic [1:0] r;
		if (group_has_four(k)) begin
			r = idx + 2'd1;
		end else begin
			r = (idx >= 2'd2) ? 2'd0 : idx + 2'd1;
		end
		return r;
	endfunction

endpackage

[hw/rtl/multi_tap_keypad_text_entry_unit.sv]
// Multi-tap keypad text entry. Each accepted word on the s_ side is one key press with its
// millisecond timestamp; the unit answers with one or two event words on the m_ side (commit,
// provisional letter, delete, field enter, mode toggle, back), tlast marking the final event of
// a press, and nothing for key A or for keys 0 and 1 in letter mode. The decoder updates the
// multi-tap state in the cycle a press is accepted, so presses may arrive every cycle while
// the queue has room; the first event of a press passes through the queue and then the output
// register; a two-event press keeps its second event in a register until the first is taken,
// and a four-entry queue between decoder and output lets the input keep flowing while the
// output is stalled. Sustained rate is one press per cycle for single-event presses while
// the output is not stalled, set by the one-word-per-cycle output port. cfg_wdata written
// with cfg_wen sets the repeat timeout in ms (1500 after reset); write it only while idle.
`include "multi_tap_keypad_text_entry_unit_defines.svh"

module multi_tap_keypad_text_entry_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wen,
	input  logic [15:0] cfg_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // key [3:0], press_time [35:4], zero [39:36]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // event_kind [2:0], char_code [9:3], alpha_mode [10], zero [15:11]
	output logic        m_tlast
);

	logic          q_push;
	logic          q_ready;
	mtk_pkg::job_t q_in;
	logic          q_pop;
	logic          q_valid;
	mtk_pkg::job_t q_out;
	mtk_pkg::rec_t out_rec;

	// Decoder and multi-tap state.
	mtk_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wen    (cfg_wen),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.key        (s_tdata[3:0]),
		.press_time (s_tdata[35:4]),
		.job_push   (q_push),
		.job_ready  (q_ready),
		.job        (q_in)
	);

	// Queue between the two halves.
	mtk_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_ready (q_ready),
		.push_job   (q_in),
		.pop        (q_pop),
		.pop_valid  (q_valid),
		.pop_job    (q_out)
	);

	// Output serializer.
	mtk_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (q_valid),
		.job_pop   (q_pop),
		.job       (q_out),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_rec   (out_rec),
		.out_last  (m_tlast)
	);

	assign m_tdata = {5'd0, out_rec.alpha, out_rec.chr, out_rec.kind};

	// The decoder never pushes into a full queue.
	`MTK_ASSERT_NOW(a_no_overflow, q_push, q_ready, "push into full queue")
	// A non-final event is always followed by the rest of its press.
	`MTK_ASSERT_NEXT(a_pair_follows, m_tvalid && !m_tlast, m_tvalid, "second event lost")
	// Only defined event kinds leave the unit.
	`MTK_ASSERT_NOW(a_kind_range, m_tvalid, m_tdata[2:0] <= mtk_pkg::KIND_BACK,
		"undefined event kind")

endmodule

[hw/rtl/mtk_front.sv]
// Decodes each key press against the multi-tap state and builds its events.
module mtk_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wen,
	input  logic [15:0]        cfg_wdata,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [3:0]         key,
	input  logic [31:0]        press_time,
	output logic               job_push,
	input  logic               job_ready,
	output mtk_pkg::job_t      job
);

	logic [15:0] timeout_q;
	logic        pend_vld_q;
	logic [3:0]  pend_key_q;
	logic [1:0]  tap_q;
	logic [31:0] stamp_q;
	logic        mode_q;

	logic        pend_vld_d;
	logic [3:0]  pend_key_d;
	logic [1:0]  tap_d;
	logic [31:0] stamp_d;
	logic        mode_d;

	logic        accept;
	logic        key_letter;
	logic        key_digit;
	logic [31:0] gap;
	logic        advance;
	logic        commit_ok;
	logic        has_main;
	logic        do_commit;
	mtk_pkg::rec_t commit_rec;
	mtk_pkg::rec_t main_rec;

	assign in_ready = job_ready;
	assign accept   = in_valid && job_ready;

	assign key_letter = (key >= mtk_pkg::KEY_TWO) && (key <= mtk_pkg::KEY_NINE);
	assign key_digit  = (key <= mtk_pkg::KEY_NINE);
	assign gap        = press_time - stamp_q;
	assign advance    = pend_vld_q && (pend_key_q == key) && (gap <= {16'd0, timeout_q});
	assign commit_ok  = pend_vld_q && (pend_key_q >= mtk_pkg::KEY_TWO)
		&& (pend_key_q <= mtk_pkg::KEY_NINE);

	// Commit of the pending letter, shown in the mode before this press.
	always_comb begin
		commit_rec.kind  = mtk_pkg::KIND_COMMIT;
		commit_rec.chr   = mtk_pkg::letter_of(pend_key_q, tap_q);
		commit_rec.alpha = mode_q;
	end

	// Next state and the main event of the press.
	always_comb begin
		pend_vld_d     = pend_vld_q;
		pend_key_d     = pend_key_q;
		tap_d          = tap_q;
		stamp_d        = stamp_q;
		mode_d         = mode_q;
		has_main       = 1'b1;
		do_commit      = commit_ok;
		main_rec.kind  = mtk_pkg::KIND_COMMIT;
		main_rec.chr   = mtk_pkg::ASCII_NONE;
		main_rec.alpha = mode_q;
		priority if (key == mtk_pkg::KEY_C) begin
			pend_vld_d     = 1'b0;
			pend_key_d     = '0;
			tap_d          = '0;
			mode_d         = !mode_q;
			main_rec.kind  = mtk_pkg::KIND_MODE;
			main_rec.alpha = !mode_q;
		end else if (mode_q && key_letter) begin
			if (advance) begin
				do_commit = 1'b0;
				tap_d     = mtk_pkg::next_tap(key, tap_q);
			end else begin
				tap_d = '0;
			end
			pend_vld_d    = 1'b1;
			pend_key_d    = key;
			stamp_d       = press_time;
			main_rec.kind = mtk_pkg::KIND_PROV;
			main_rec.chr  = mtk_pkg::letter_of(key, tap_d);
		end else if (key == mtk_pkg::KEY_D || key == mtk_pkg::KEY_STAR
				|| key == mtk_pkg::KEY_B || key == mtk_pkg::KEY_HASH
				|| (!mode_q && key_digit)) begin
			pend_vld_d = 1'b0;
			pend_key_d = '0;
			tap_d      = '0;
			unique case (key)
				mtk_pkg::KEY_D: begin
					main_rec.kind = mtk_pkg::KIND_COMMIT;
					main_rec.chr  = mtk_pkg::ASCII_SPACE;
				end
				mtk_pkg::KEY_STAR: main_rec.kind = mtk_pkg::KIND_DELETE;
				mtk_pkg::KEY_B:    main_rec.kind = mtk_pkg::KIND_BACK;
				mtk_pkg::KEY_HASH: main_rec.kind = mtk_pkg::KIND_ENTER;
				default: begin
					main_rec.kind = mtk_pkg::KIND_COMMIT;
					main_rec.chr  = mtk_pkg::ASCII_ZERO + {3'd0, key};
				end
			endcase
		end else begin
			// Key A, or 0 and 1 while in letter mode: nothing happens.
			has_main  = 1'b0;
			do_commit = 1'b0;
		end
	end

	// Pack the events: the commit, when present, comes first.
	always_comb begin
		job.two    = do_commit;
		job.first  = do_commit ? commit_rec : main_rec;
		job.second = main_rec;
	end

	assign job_push = accept && has_main;

	// Configuration and multi-tap state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q  <= mtk_pkg::TIMEOUT_RST;
			pend_vld_q <= 1'b0;
			pend_key_q <= '0;
			tap_q      <= '0;
			stamp_q    <= '0;
			mode_q     <= 1'b1;
		end else begin
			if (cfg_wen) begin
				timeout_q <= cfg_wdata;
			end
			if (accept) begin
				pend_vld_q <= pend_vld_d;
				pend_key_q <= pend_key_d;
				tap_q      <= tap_d;
				stamp_q    <= stamp_d;
				mode_q     <= mode_d;
			end
		end
	end

endmodule

[hw/rtl/mtk_queue.sv]
// Short queue of decoded presses between the decoder and the output side.
module mtk_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	output logic          push_ready,
	input  mtk_pkg::job_t push_job,
	input  logic          pop,
	output logic          pop_valid,
	output mtk_pkg::job_t pop_job
);

	mtk_pkg::job_t                  slot_q [mtk_pkg::QUEUE_DEPTH];
	logic [mtk_pkg::QPTR_W-1:0]     wr_ptr_q;
	logic [mtk_pkg::QPTR_W-1:0]     rd_ptr_q;
	logic [mtk_pkg::QCNT_W-1:0]     count_q;
	logic                           do_push;
	logic                           do_pop;

	assign push_ready = (count_q != mtk_pkg::QCNT_W'(mtk_pkg::QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_job    = slot_q[rd_ptr_q];
	assign do_push    = push && push_ready;
	assign do_pop     = pop && pop_valid;

	// Storage holds payload only.
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_job;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[hw/rtl/mtk_back.sv]
// Serializes queued presses into one event word per cycle on the output while it is not stalled.
module mtk_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          job_valid,
	output logic          job_pop,
	input  mtk_pkg::job_t job,
	output logic          out_valid,
	input  logic          out_ready,
	output mtk_pkg::rec_t out_rec,
	output logic          out_last
);

	logic          out_vld_q;
	mtk_pkg::rec_t out_rec_q;
	logic          out_last_q;
	logic          pend_q;
	mtk_pkg::rec_t pend_rec_q;
	logic          slot_free;

	assign slot_free = !out_vld_q || out_ready;
	assign job_pop   = slot_free && !pend_q && job_valid;

	assign out_valid = out_vld_q;
	assign out_rec   = out_rec_q;
	assign out_last  = out_last_q;

	// Output register, fed by the held second event before a new press.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
			pend_q    <= 1'b0;
		end else if (slot_free) begin
			if (pend_q) begin
				out_vld_q <= 1'b1;
				pend_q    <= 1'b0;
			end else begin
				out_vld_q <= job_valid;
				pend_q    <= job_valid && job.two;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (slot_free) begin
			if (pend_q) begin
				out_rec_q  <= pend_rec_q;
				out_last_q <= 1'b1;
			end else if (job_valid) begin
				out_rec_q  <= job.first;
				out_last_q <= !job.two;
				pend_rec_q <= job.second;
			end
		end
	end

endmodule
